### src/sbr_pkg.sv
// shared types and codes for the stream byte reassembler
// command/status structs between controller and datapath; no dependencies
package sbr_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_SET_END = 2'd1,
    CMD_POP     = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REDUNDANT = 2'd1,
    ST_DROPPED   = 2'd2
  } ins_st_t;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 88;

  typedef struct packed {
    logic    load_in;
    logic    clr_step;
    logic    calc_a;
    logic    calc_b;
    logic    prd_slot;
    logic    prd_head;
    logic    ins_wr;
    logic    adv;
    logic    set_end;
    logic    pop_rd;
    logic    pop_take;
    logic    chk_close;
    logic    set_status;
    ins_st_t status;
    logic    out_load;
  } sbr_cmd_t;

  typedef struct packed {
    logic clr_done;
    cmd_t cmd;
    logic closed;
    logic last;
    logic in_win;
    logic pres;
    logic waiting_nz;
    logic can_pop;
    logic out_busy;
  } sbr_sts_t;

endpackage

### src/sbr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### src/sbr_ctrl.sv
// controller state machine of the stream byte reassembler
// depends on sbr_pkg; drives sbr_dp through sbr_cmd_t
module sbr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  sbr_pkg::sbr_sts_t sts,
  output sbr_pkg::sbr_cmd_t cmd
);
  import sbr_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_CALC_A,
    S_CALC_B,
    S_PRD,
    S_PCHK,
    S_HREAD,
    S_HCHK,
    S_POP_WAIT,
    S_FIN,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.cmd)
          CMD_INSERT: begin
            if (sts.closed) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_DROPPED;
              state_nxt      = S_FIN;
            end else begin
              cmd.set_end = sts.last;
              state_nxt   = S_CALC_A;
            end
          end
          CMD_SET_END: begin
            cmd.set_end = 1'b1;
            state_nxt   = S_FIN;
          end
          CMD_POP: begin
            if (sts.can_pop) begin
              cmd.pop_rd = 1'b1;
              state_nxt  = S_POP_WAIT;
            end else begin
              state_nxt = S_FIN;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_CALC_A: begin
        cmd.calc_a = 1'b1;
        state_nxt  = S_CALC_B;
      end
      S_CALC_B: begin
        cmd.calc_b = 1'b1;
        state_nxt  = S_PRD;
      end
      S_PRD: begin
        if (sts.in_win) begin
          cmd.prd_slot = 1'b1;
          state_nxt    = S_PCHK;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_DROPPED;
          state_nxt      = S_FIN;
        end
      end
      S_PCHK: begin
        if (sts.pres) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_REDUNDANT;
          state_nxt      = S_FIN;
        end else begin
          cmd.ins_wr = 1'b1;
          state_nxt  = S_HREAD;
        end
      end
      S_HREAD: begin
        cmd.prd_head = 1'b1;
        state_nxt    = S_HCHK;
      end
      S_HCHK: begin
        if (sts.pres && sts.waiting_nz) begin
          cmd.adv   = 1'b1;
          state_nxt = S_HREAD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_POP_WAIT: begin
        cmd.pop_take = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        cmd.chk_close = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/sbr_dp.sv
// datapath of the stream byte reassembler: counters, window check, ring stores
// depends on sbr_pkg and sbr_ram; controlled by sbr_ctrl
module sbr_dp #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [sbr_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic [1:0]                           in_tuser,
  input  logic                                 in_tlast,
  input  sbr_pkg::sbr_cmd_t                    cmd,
  output sbr_pkg::sbr_sts_t                    sts,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sbr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tuser
);
  import sbr_pkg::*;

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned WCNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
  localparam logic [IDX_W:0]   CAP_S     = (IDX_W + 1)'(CAPACITY);
  localparam logic [63:0]      CAP_W     = 64'(CAPACITY);

  // captured item
  logic [63:0] pos_r;
  logic [7:0]  val_r;
  logic        last_r;
  cmd_t        cmd_r;

  // stream state
  logic [63:0]       asm_r, asm_nxt;
  logic [63:0]       cons_r, cons_nxt;
  logic [63:0]       endpos_r, endpos_nxt;
  logic              end_known_r, end_known_nxt;
  logic              closed_r, closed_nxt;
  logic [WCNT_W-1:0] wcnt_r, wcnt_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  cslot_r, cslot_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;

  // per-item work registers
  logic             lt_r;
  logic [IDX_W-1:0] off_r;
  logic [IDX_W-1:0] slot_r;
  logic             inwin_r;
  logic [7:0]       pbyte_r;
  logic             pvalid_r;
  ins_st_t          status_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic             out_tuser_r;

  logic [64:0]      sub_a;
  logic [63:0]      sub_c;
  logic [IDX_W:0]   slot_sum;
  logic [IDX_W-1:0] slot_calc;
  logic             pres_rd;
  logic [7:0]       byte_rd;
  logic             pres_we;
  logic [IDX_W-1:0] pres_waddr;
  logic [IDX_W-1:0] pres_raddr;
  logic [WCNT_W+8:0] wcnt_ext;

  assign sub_a    = {1'b0, pos_r} - {1'b0, asm_r};
  assign sub_c    = pos_r - cons_r;
  assign slot_sum = {1'b0, head_r} + {1'b0, off_r};
  assign slot_calc = (slot_sum >= CAP_S) ? IDX_W'(slot_sum - CAP_S) : slot_sum[IDX_W-1:0];
  assign wcnt_ext = {9'd0, wcnt_r};

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
    slot_inc = (s == LAST_SLOT) ? '0 : s + IDX_W'(1);
  endfunction

  // present bits ring
  assign pres_we    = cmd.clr_step | cmd.ins_wr | cmd.adv;
  assign pres_waddr = cmd.clr_step ? clr_r : (cmd.ins_wr ? slot_r : head_r);
  assign pres_raddr = cmd.prd_slot ? slot_r : head_r;

  sbr_ram #(
    .WIDTH (1),
    .DEPTH (CAPACITY)
  ) u_present (
    .clk   (clk),
    .we    (pres_we),
    .waddr (pres_waddr),
    .wdata (cmd.ins_wr),
    .re    (cmd.prd_slot | cmd.prd_head),
    .raddr (pres_raddr),
    .rdata (pres_rd)
  );

  // byte ring
  sbr_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_bytes (
    .clk   (clk),
    .we    (cmd.ins_wr),
    .waddr (slot_r),
    .wdata (val_r),
    .re    (cmd.pop_rd),
    .raddr (cslot_r),
    .rdata (byte_rd)
  );

  always_comb begin
    asm_nxt        = asm_r;
    cons_nxt       = cons_r;
    endpos_nxt     = endpos_r;
    end_known_nxt  = end_known_r;
    closed_nxt     = closed_r;
    wcnt_nxt       = wcnt_r;
    head_nxt       = head_r;
    cslot_nxt      = cslot_r;
    clr_nxt        = clr_r;
    out_tvalid_nxt = out_tvalid_r;

    if (cmd.clr_step) begin
      clr_nxt = slot_inc(clr_r);
    end
    if (cmd.set_end) begin
      end_known_nxt = 1'b1;
      endpos_nxt    = (cmd_r == CMD_INSERT) ? pos_r + 64'd1 : pos_r;
    end
    if (cmd.ins_wr) begin
      wcnt_nxt = wcnt_r + WCNT_W'(1);
    end
    if (cmd.adv) begin
      wcnt_nxt = wcnt_r - WCNT_W'(1);
      asm_nxt  = asm_r + 64'd1;
      head_nxt = slot_inc(head_r);
    end
    if (cmd.pop_rd) begin
      cons_nxt  = cons_r + 64'd1;
      cslot_nxt = slot_inc(cslot_r);
    end
    if (cmd.chk_close && end_known_r && (asm_r == endpos_r)) begin
      closed_nxt = 1'b1;
    end
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_r        <= '0;
      cons_r       <= '0;
      endpos_r     <= '0;
      end_known_r  <= 1'b0;
      closed_r     <= 1'b0;
      wcnt_r       <= '0;
      head_r       <= '0;
      cslot_r      <= '0;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      asm_r        <= asm_nxt;
      cons_r       <= cons_nxt;
      endpos_r     <= endpos_nxt;
      end_known_r  <= end_known_nxt;
      closed_r     <= closed_nxt;
      wcnt_r       <= wcnt_nxt;
      head_r       <= head_nxt;
      cslot_r      <= cslot_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pos_r    <= in_tdata[63:0];
      val_r    <= in_tdata[71:64];
      last_r   <= in_tlast;
      cmd_r    <= cmd_t'(in_tuser);
      pbyte_r  <= '0;
      pvalid_r <= 1'b0;
      status_r <= ST_OK;
    end
    if (cmd.calc_a) begin
      lt_r  <= sub_a[64];
      off_r <= sub_a[IDX_W-1:0];
    end
    if (cmd.calc_b) begin
      inwin_r <= !lt_r && (sub_c < CAP_W);
      slot_r  <= slot_calc;
    end
    if (cmd.pop_take) begin
      pbyte_r  <= byte_rd;
      pvalid_r <= 1'b1;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.out_load) begin
      out_tdata_r <= {4'd0, status_r, closed_r, wcnt_ext[8:0], asm_r, pbyte_r};
      out_tuser_r <= pvalid_r;
    end
  end

  assign sts.clr_done   = (clr_r == LAST_SLOT);
  assign sts.cmd        = cmd_r;
  assign sts.closed     = closed_r;
  assign sts.last       = last_r;
  assign sts.in_win     = inwin_r;
  assign sts.pres       = pres_rd;
  assign sts.waiting_nz = (wcnt_r != '0);
  assign sts.can_pop    = (cons_r < asm_r);
  assign sts.out_busy   = out_tvalid_r & ~out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

### src/stream_byte_reassembler.sv
// stream byte reassembler: bytes arrive one per item with their absolute stream
// index and are stored in a ring of CAPACITY slots, then handed out in order by
// pop items. One item is worked at a time and every item yields one result item.
// After reset a clearing pass writes every slot of the present-bit ring, with
// in_tready low. A pop that returns a byte waits on a registered read of the
// byte ring; a stored insert then advances the head over every byte that joins
// the assembled run, reading one present bit per step through the single read
// port of the present-bit ring. A redundant insert, one outside the window and
// one after close are not stored and yield only a status. The result sits in an
// output register, so a result waiting on out_tready holds only the next one.
// depends on sbr_pkg, sbr_ctrl, sbr_dp
module stream_byte_reassembler #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sbr_pkg::IN_TDATA_W-1:0] in_tdata,   // stream_index, byte_value
  input  logic [1:0]                     in_tuser,   // command
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // popped_byte, bytes_assembled, bytes_waiting, stream_closed, insert_status
  output logic [sbr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tuser   // popped_valid
);
  import sbr_pkg::*;

  sbr_cmd_t cmd;
  sbr_sts_t sts;

  sbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbr_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sts.closed |=> sts.closed)
    else $error("stream closed flag dropped");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in work");

  a_pop_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[83:82] == ST_OK))
    else $error("popped item carries an insert status");
`endif

endmodule
